// ===== rtl/iab_pkg.sv =====
package iab_pkg;

    localparam int WORD_BITS     = 16;
    localparam int WINDOW_WORDS  = 4;
    localparam int STORE_WINDOWS = 2;
    localparam int ADDR_BITS     = 16;

    localparam int TOTAL_WORDS = WINDOW_WORDS * STORE_WINDOWS;
    localparam int WINDOW_BITS = WORD_BITS * WINDOW_WORDS;
    localparam int STORE_BITS  = WINDOW_BITS * STORE_WINDOWS;
    localparam int BYTES_PER_WORD = WORD_BITS / 8;
    localparam int COUNT_W     = 4;
    localparam int USED_W      = 4;
    localparam int CODE_W      = 5;
    localparam int SHIFT_W     = 8;

    // source fields, offsets counted from the top of the head window
    localparam int SRC1_MSB = WINDOW_BITS - 1 - 6;
    localparam int SRC2_MSB = WINDOW_BITS - 1 - 11;

    localparam int MODE_W    = 2;
    localparam int IN_DATA_W = 88;
    localparam int OUT_DATA_W = 88;

    localparam logic [CODE_W-1:0] IMM_CODE_RST  = 5'd1;
    localparam logic [CODE_W-1:0] ADDR_CODE_RST = 5'd2;

    typedef enum logic [0:0] {
        CFG_IMMEDIATE_CODE = 1'b0,
        CFG_ADDRESS_CODE   = 1'b1
    } cfg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD    = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_CONSUME = 2'd2,
        MODE_DISCARD = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_SEND = 2'd2
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

// ===== rtl/iab_ctrl.sv =====
module iab_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_ready,
    output logic               in_ready,
    output logic               out_valid,
    output iab_pkg::ctrl_cmd_t cmd
);

    iab_pkg::state_t state_reg;
    iab_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iab_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iab_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = iab_pkg::ST_EXEC;
                end
            end
            iab_pkg::ST_EXEC:
            begin
                state_next = iab_pkg::ST_SEND;
            end
            iab_pkg::ST_SEND:
            begin
                if (out_ready)
                begin
                    state_next = iab_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iab_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            iab_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            iab_pkg::ST_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            iab_pkg::ST_SEND:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/iab_datapath.sv =====
module iab_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  iab_pkg::ctrl_cmd_t                    cmd,
    input  logic                                  cfg_wen,
    input  logic                                  cfg_addr,
    input  logic [iab_pkg::CODE_W-1:0]            cfg_wdata,
    input  logic [iab_pkg::MODE_W-1:0]            mode,
    input  logic [iab_pkg::WINDOW_BITS-1:0]       window_data,
    input  logic [iab_pkg::ADDR_BITS-1:0]         window_address,
    input  logic [iab_pkg::USED_W-1:0]            used_words,
    output logic [iab_pkg::WINDOW_BITS-1:0]       head_window,
    output logic [iab_pkg::ADDR_BITS-1:0]         head_address,
    output logic [iab_pkg::COUNT_W-1:0]           valid_words,
    output logic                                  instr_ready,
    output logic                                  append_error
);

    localparam int SW = iab_pkg::SHIFT_W;

    logic [iab_pkg::CODE_W-1:0]      imm_code_reg;
    logic [iab_pkg::CODE_W-1:0]      addr_code_reg;

    iab_pkg::mode_t                  mode_reg;
    logic [iab_pkg::WINDOW_BITS-1:0] data_reg;
    logic [iab_pkg::ADDR_BITS-1:0]   waddr_reg;
    logic [iab_pkg::USED_W-1:0]      used_reg;

    logic [iab_pkg::STORE_BITS-1:0]  store_reg;
    logic [iab_pkg::STORE_BITS-1:0]  store_next;
    logic [iab_pkg::ADDR_BITS-1:0]   addr_reg;
    logic [iab_pkg::ADDR_BITS-1:0]   addr_next;
    logic [iab_pkg::COUNT_W-1:0]     count_reg;
    logic [iab_pkg::COUNT_W-1:0]     count_next;
    logic                            err_reg;
    logic                            err_next;

    logic [iab_pkg::STORE_BITS-1:0]  window_top;
    logic [SW-1:0]                   count_sh;
    logic [SW-1:0]                   used_sh;
    logic [iab_pkg::STORE_BITS-1:0]  keep_mask;
    logic [iab_pkg::CODE_W-1:0]      src1;
    logic [iab_pkg::CODE_W-1:0]      src2;
    logic                            extra1;
    logic                            extra2;
    logic [iab_pkg::COUNT_W-1:0]     needed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            imm_code_reg  <= iab_pkg::IMM_CODE_RST;
            addr_code_reg <= iab_pkg::ADDR_CODE_RST;
        end
        else if (cfg_wen)
        begin
            unique case (iab_pkg::cfg_index_t'(cfg_addr))
                iab_pkg::CFG_IMMEDIATE_CODE: imm_code_reg  <= cfg_wdata;
                iab_pkg::CFG_ADDRESS_CODE:   addr_code_reg <= cfg_wdata;
                default:                     imm_code_reg  <= imm_code_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= iab_pkg::mode_t'(mode);
            data_reg  <= window_data;
            waddr_reg <= window_address;
            used_reg  <= used_words;
        end
    end

    assign window_top = {data_reg, {(iab_pkg::STORE_BITS - iab_pkg::WINDOW_BITS){1'b0}}};
    assign count_sh   = SW'(count_reg) * SW'(iab_pkg::WORD_BITS);
    assign used_sh    = SW'(used_reg) * SW'(iab_pkg::WORD_BITS);
    assign keep_mask  = ~({iab_pkg::STORE_BITS{1'b1}} >> count_sh);

    always_comb
    begin
        store_next = store_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        err_next   = 1'b0;
        unique case (mode_reg)
            iab_pkg::MODE_LOAD:
            begin
                store_next = window_top;
                addr_next  = waddr_reg;
                count_next = iab_pkg::COUNT_W'(iab_pkg::WINDOW_WORDS);
            end
            iab_pkg::MODE_APPEND:
            begin
                if (count_reg >= iab_pkg::COUNT_W'(iab_pkg::WINDOW_WORDS))
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    store_next = (store_reg & keep_mask) | (window_top >> count_sh);
                    count_next = count_reg + iab_pkg::COUNT_W'(iab_pkg::WINDOW_WORDS);
                end
            end
            iab_pkg::MODE_CONSUME:
            begin
                store_next = store_reg << used_sh;
                addr_next  = addr_reg + iab_pkg::ADDR_BITS'(used_reg)
                             * iab_pkg::ADDR_BITS'(iab_pkg::BYTES_PER_WORD);
                count_next = (count_reg > used_reg) ? count_reg - used_reg
                                                    : '0;
            end
            iab_pkg::MODE_DISCARD:
            begin
                store_next = '0;
                count_next = '0;
            end
            default:
            begin
                err_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            addr_reg  <= '0;
            count_reg <= '0;
            err_reg   <= 1'b0;
        end
        else if (cmd.execute)
        begin
            store_reg <= store_next;
            addr_reg  <= addr_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    // result is read straight from the state while it is held for the sink
    assign head_window = store_reg[iab_pkg::STORE_BITS-1 -: iab_pkg::WINDOW_BITS];
    assign src1   = head_window[iab_pkg::SRC1_MSB -: iab_pkg::CODE_W];
    assign src2   = head_window[iab_pkg::SRC2_MSB -: iab_pkg::CODE_W];
    assign extra1 = (src1 == imm_code_reg) || (src1 == addr_code_reg);
    assign extra2 = (src2 == imm_code_reg) || (src2 == addr_code_reg);
    assign needed = iab_pkg::COUNT_W'(1) + iab_pkg::COUNT_W'(extra1)
                    + iab_pkg::COUNT_W'(extra2);

    assign head_address = addr_reg;
    assign valid_words  = count_reg;
    assign instr_ready  = (count_reg >= needed);
    assign append_error = err_reg;

endmodule

// ===== rtl/instruction_align_buffer.sv =====
// Instruction align buffer: two fetch windows of 16-bit words, head address
// and valid word count, updated by one operation per transfer.
// Input channel s_*: s_tuser carries the mode (load, append, consume,
// discard); s_tdata carries the window, its address and the consume count.
// Output channel m_*: one result per input transfer with the head window,
// head address, count, instruction-ready flag and append error flag.
// Config port: cfg_wen writes cfg_wdata to register cfg_addr
// (0 immediate code, 1 address code); write only while the block is idle.
// After an input transfer the controller passes through the update state
// and then raises m_tvalid in the present state. One item is handled at a
// time by the three-state controller (capture, update, present).
// The result is held on m_tdata until m_tready; no new input is taken
// meanwhile.
// Reset clears the buffer, address and count, and sets the codes to 1 and 2.
module instruction_align_buffer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic                               cfg_addr,
    input  logic [iab_pkg::CODE_W-1:0]         cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // window_data[63:0], window_address[79:64], used_words[83:80], zero pad
    input  logic [iab_pkg::IN_DATA_W-1:0]      s_tdata,
    // mode[1:0]
    input  logic [iab_pkg::MODE_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // head_window[63:0], head_address[79:64], valid_words[83:80],
    // instr_ready[84], append_error[85], zero pad
    output logic [iab_pkg::OUT_DATA_W-1:0]     m_tdata
);

    iab_pkg::ctrl_cmd_t              cmd;
    logic [iab_pkg::WINDOW_BITS-1:0] head_window;
    logic [iab_pkg::ADDR_BITS-1:0]   head_address;
    logic [iab_pkg::COUNT_W-1:0]     valid_words;
    logic                            instr_ready;
    logic                            append_error;

    iab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .cmd       (cmd)
    );

    iab_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_wen        (cfg_wen),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mode           (s_tuser),
        .window_data    (s_tdata[63:0]),
        .window_address (s_tdata[79:64]),
        .used_words     (s_tdata[83:80]),
        .head_window    (head_window),
        .head_address   (head_address),
        .valid_words    (valid_words),
        .instr_ready    (instr_ready),
        .append_error   (append_error)
    );

    assign m_tdata = {2'b00, append_error, instr_ready, valid_words,
                      head_address, head_window};

endmodule

// ===== tb/instruction_align_buffer_tb.sv =====
`timescale 1ns / 1ps

module instruction_align_buffer_tb;

    import iab_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic                  append_error;
        logic                  instr_ready;
        logic [COUNT_W-1:0]    valid_words;
        logic [ADDR_BITS-1:0]  head_address;
        logic [WINDOW_BITS-1:0] head_window;
    } buffer_view_t;

    class align_scoreboard;
        logic [WORD_BITS-1:0] words [TOTAL_WORDS];
        logic [ADDR_BITS-1:0] start_addr;
        int unsigned          count;
        logic [CODE_W-1:0]    imm_code;
        logic [CODE_W-1:0]    addr_code;
        buffer_view_t         expected_views [$];
        int                   errors;

        function new();
            foreach (words[i])
                words[i] = '0;
            start_addr = '0;
            count      = 0;
            imm_code   = IMM_CODE_RST;
            addr_code  = ADDR_CODE_RST;
            errors     = 0;
        endfunction

        function void set_codes(logic [CODE_W-1:0] imm, logic [CODE_W-1:0] adr);
            imm_code  = imm;
            addr_code = adr;
        endfunction

        function int pending();
            return expected_views.size();
        endfunction

        function bit is_extra(logic [CODE_W-1:0] code);
            return code == imm_code || code == addr_code;
        endfunction

        // apply one buffer operation and queue the view it should produce
        function void note_transfer(mode_t mode, logic [WINDOW_BITS-1:0] data,
                                    logic [ADDR_BITS-1:0] addr, logic [USED_W-1:0] used);
            buffer_view_t         v;
            logic [WORD_BITS-1:0] fresh [WINDOW_WORDS];
            logic [WINDOW_BITS-1:0] head;
            int                   needed;
            v = '0;
            for (int k = 0; k < WINDOW_WORDS; k++)
                fresh[k] = data[WINDOW_BITS-1-k*WORD_BITS -: WORD_BITS];
            case (mode)
                MODE_LOAD:
                begin
                    for (int i = 0; i < TOTAL_WORDS; i++)
                        words[i] = (i < WINDOW_WORDS) ? fresh[i] : '0;
                    start_addr = addr;
                    count      = WINDOW_WORDS;
                end
                MODE_APPEND:
                begin
                    if (count >= WINDOW_WORDS)
                        v.append_error = 1'b1;
                    else
                    begin
                        for (int i = count; i < TOTAL_WORDS; i++)
                            words[i] = (i - count < WINDOW_WORDS) ? fresh[i - count] : '0;
                        count += WINDOW_WORDS;
                    end
                end
                MODE_CONSUME:
                begin
                    for (int i = 0; i < TOTAL_WORDS; i++)
                        words[i] = (i + used < TOTAL_WORDS) ? words[i + used] : '0;
                    start_addr = start_addr + ADDR_BITS'(int'(used) * BYTES_PER_WORD);
                    count      = (count > used) ? count - used : 0;
                end
                default:
                begin
                    foreach (words[i])
                        words[i] = '0;
                    count = 0;
                end
            endcase
            for (int k = 0; k < WINDOW_WORDS; k++)
                head[WINDOW_BITS-1-k*WORD_BITS -: WORD_BITS] = words[k];
            needed = 1;
            if (is_extra(head[SRC1_MSB -: CODE_W]))
                needed++;
            if (is_extra(head[SRC2_MSB -: CODE_W]))
                needed++;
            v.head_window  = head;
            v.head_address = start_addr;
            v.valid_words  = COUNT_W'(count);
            v.instr_ready  = (count >= needed);
            expected_views.push_back(v);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(buffer_view_t got);
            buffer_view_t want;
            if (expected_views.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_views.pop_front();
            compare("head_window", want.head_window, got.head_window);
            compare("head_address", want.head_address, got.head_address);
            compare("valid_words", want.valid_words, got.valid_words);
            compare("instr_ready", want.instr_ready, got.instr_ready);
            compare("append_error", want.append_error, got.append_error);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic                  cfg_addr;
    logic [CODE_W-1:0]     cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // window_data, window_address, used_words, zero pad
    logic [IN_DATA_W-1:0]  s_tdata;
    // mode
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // head_window, head_address, valid_words, instr_ready, append_error, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;

    align_scoreboard sb = new();
    bit quiet;
    int stall_left;
    int idle_cycles;

    instruction_align_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (quiet)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25)
                stall_left <= $urandom_range(1, 3);
            else if ($urandom_range(0, 99) < 4)
                stall_left <= $urandom_range(10, 30);
        end
    end

    // transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_transfer(mode_t'(s_tuser), s_tdata[WINDOW_BITS-1:0],
                             s_tdata[WINDOW_BITS +: ADDR_BITS],
                             s_tdata[WINDOW_BITS+ADDR_BITS +: USED_W]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[$bits(buffer_view_t)-1:0]);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // random window, often with source fields set to the live codes
    function logic [WINDOW_BITS-1:0] make_window();
        logic [WINDOW_BITS-1:0] w;
        w = {$urandom, $urandom};
        for (int k = 0; k < WINDOW_WORDS; k++)
        begin
            if ($urandom_range(0, 1))
            begin
                w[k*WORD_BITS+5 +: CODE_W] = $urandom_range(0, 1) ? sb.imm_code : sb.addr_code;
                case ($urandom_range(0, 2))
                    0: w[k*WORD_BITS +: CODE_W] = sb.imm_code;
                    1: w[k*WORD_BITS +: CODE_W] = sb.addr_code;
                    default: ;
                endcase
            end
        end
        return w;
    endfunction

    task automatic send_item(mode_t mode, logic [WINDOW_BITS-1:0] data,
                             logic [ADDR_BITS-1:0] addr, logic [USED_W-1:0] used);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(IN_DATA_W-WINDOW_BITS-ADDR_BITS-USED_W){1'b0}}, used, addr, data};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop sending and let every outstanding result arrive
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_codes(logic [CODE_W-1:0] imm, logic [CODE_W-1:0] adr);
        cfg_wen   <= 1'b1;
        cfg_addr  <= CFG_IMMEDIATE_CODE;
        cfg_wdata <= imm;
        @(posedge clk);
        cfg_addr  <= CFG_ADDRESS_CODE;
        cfg_wdata <= adr;
        @(posedge clk);
        cfg_wen <= 1'b0;
        sb.set_codes(imm, adr);
    endtask

    task automatic random_item();
        mode_t mode;
        int    r;
        int    used;
        r = $urandom_range(0, 99);
        if (r < 25)
            mode = MODE_LOAD;
        else if (r < 55)
            mode = MODE_APPEND;
        else if (r < 92)
            mode = MODE_CONSUME;
        else
            mode = MODE_DISCARD;
        used = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
        send_item(mode, make_window(), ADDR_BITS'($urandom), USED_W'(used));
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            quiet = (i < 30);
            if (i > 30 && $urandom_range(0, 99) == 0)
                drain();
            random_item();
        end
        quiet = 1'b0;
    endtask

    task automatic directed_items();
        send_item(MODE_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 4'd0);
        send_item(MODE_APPEND, 64'h1111_2222_3333_4444, 16'hFFFF, 4'd15);
        send_item(MODE_CONSUME, 64'h0, 16'h0, 4'd1);
        send_item(MODE_APPEND, 64'h0000_0000_0000_0000, 16'h0, 4'd0);
        send_item(MODE_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'd15);
        send_item(MODE_CONSUME, 64'h0, 16'h0, 4'd0);
        // both source fields name an extra word
        send_item(MODE_LOAD, 64'h0022_0000_0000_0000, 16'hFFFF, 4'd0);
        send_item(MODE_CONSUME, 64'h0, 16'h0, 4'd2);
        send_item(MODE_LOAD, 64'h0021_0000_0000_0042, 16'h0000, 4'd0);
        send_item(MODE_CONSUME, 64'h0, 16'h0, 4'd3);
        send_item(MODE_APPEND, 64'h1234_5678_9ABC_DEF0, 16'h0, 4'd0);
        send_item(MODE_CONSUME, 64'h0, 16'h0, 4'd8);
        // address wraps on consume
        send_item(MODE_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFE, 4'd0);
        send_item(MODE_CONSUME, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'd15);
        send_item(MODE_LOAD, 64'h0, 16'h0000, 4'd0);
        send_item(MODE_CONSUME, 64'h0, 16'h0, 4'd9);
        send_item(MODE_LOAD, 64'hA5A5_5A5A_0F0F_F0F0, 16'h8000, 4'd0);
        send_item(MODE_DISCARD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'd15);
        send_item(MODE_APPEND, 64'h0041_0022_0001_0002, 16'h0, 4'd0);
        send_item(MODE_CONSUME, 64'h0, 16'h0, 4'd5);
        send_item(MODE_LOAD, 64'h0041_0000_0000_0000, 16'h7FFF, 4'd0);
        send_item(MODE_CONSUME, 64'h0, 16'h0, 4'd4);
        send_item(MODE_DISCARD, 64'h0, 16'h0, 4'd0);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        cfg_wen    <= 1'b0;
        cfg_addr   <= CFG_IMMEDIATE_CODE;
        cfg_wdata  <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= MODE_LOAD;
        m_tready   <= 1'b0;
        quiet       = 1'b0;
        stall_left  = 0;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        run_random(250);
        drain();

        // codes at the extremes, arbitrary codes, then equal codes again
        write_codes(5'd0, 5'd0);
        run_random(240);
        drain();
        write_codes(5'd31, 5'd31);
        run_random(240);
        drain();
        write_codes(5'd0, 5'd31);
        run_random(240);
        drain();
        write_codes(5'd31, 5'd0);
        run_random(240);
        drain();
        write_codes(CODE_W'($urandom_range(0, 31)), CODE_W'($urandom_range(0, 31)));
        run_random(240);
        drain();
        write_codes(5'd7, 5'd7);
        run_random(240);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
